@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the deque RTL.
// Every check is clocked on the rising edge and disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define BDQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define BDQ_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

@@ rtl/core/bdq_pkg.sv @@
// ----------------------------------------------------------------------------
// bdq_pkg
// Command and status codes, the decoded operation and shared sizes.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int unsigned BDQ_CAPACITY = 16;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam logic [2:0] CMD_INS_REAR  = 3'd0;
  localparam logic [2:0] CMD_INS_FRONT = 3'd1;
  localparam logic [2:0] CMD_DEL_FRONT = 3'd2;
  localparam logic [2:0] CMD_DEL_REAR  = 3'd3;
  localparam logic [2:0] CMD_DUMP      = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    OP_INS_REAR,
    OP_INS_FRONT,
    OP_DEL_FRONT,
    OP_DEL_REAR,
    OP_DUMP
  } op_e;

  typedef struct packed {
    op_e                op;
    logic signed [31:0] value;
  } op_t;

endpackage

@@ rtl/core/bounded_double_ended_queue_top.sv @@
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_top
// Results pass the operation queue and the result register; deletes and dumps
// also pass the ring read register. A dump then gives one element per cycle,
// inserts one per cycle, while out_ready_i allows; a delete's read holds off
// the next. Reset clears the front position, element count and all handshakes.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_top #(
  parameter int unsigned CAPACITY = bdq_pkg::BDQ_CAPACITY
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         cmd_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] element_o,
  output logic               last_o
);
  import bdq_pkg::*;

  logic q_ready;
  logic push;
  op_t  push_item;
  logic q_valid;
  op_t  q_item;
  logic q_pop;

  bdq_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .value_i     (value_i),
    .q_ready_i   (q_ready),
    .push_o      (push),
    .push_item_o (push_item)
  );

  bdq_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .ready_o     (q_ready),
    .valid_o     (q_valid),
    .item_o      (q_item),
    .pop_i       (q_pop)
  );

  bdq_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .element_o   (element_o),
    .last_o      (last_o)
  );

endmodule

@@ rtl/core/bdq_front.sv @@
// ----------------------------------------------------------------------------
// bdq_front
// Accepts input items and decodes the command into an operation.
// ----------------------------------------------------------------------------
module bdq_front (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         cmd_i,
  input  logic signed [31:0] value_i,
  input  logic               q_ready_i,
  output logic               push_o,
  output bdq_pkg::op_t       push_item_o
);
  import bdq_pkg::*;

  logic defined;

  always_comb begin
    defined          = 1'b1;
    push_item_o.op    = OP_INS_REAR;
    push_item_o.value = value_i;
    unique case (cmd_i)
      CMD_INS_REAR:  push_item_o.op = OP_INS_REAR;
      CMD_INS_FRONT: push_item_o.op = OP_INS_FRONT;
      CMD_DEL_FRONT: push_item_o.op = OP_DEL_FRONT;
      CMD_DEL_REAR:  push_item_o.op = OP_DEL_REAR;
      CMD_DUMP:      push_item_o.op = OP_DUMP;
      default:       defined = 1'b0;
    endcase
  end

  // Undefined commands are accepted and dropped without a result.
  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i && q_ready_i && defined;

endmodule

@@ rtl/core/bdq_queue.sv @@
// ----------------------------------------------------------------------------
// bdq_queue
// Short operation queue that decouples the decoder from the execution unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bdq_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  bdq_pkg::op_t push_item_i,
  output logic         ready_o,
  output logic         valid_o,
  output bdq_pkg::op_t item_o,
  input  logic         pop_i
);
  import bdq_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(QUEUE_DEPTH);

  op_t              slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign ready_o = (cnt_q != DEPTH_C);
  assign valid_o = (cnt_q != '0);
  assign item_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

  `BDQ_ASSERT(a_pop_not_empty, clk_i, rst_ni, pop_i |-> valid_o, "pop from an empty queue")

endmodule

@@ rtl/core/bdq_back.sv @@
// ----------------------------------------------------------------------------
// bdq_back
// Executes queued operations on the ring store and holds the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bdq_back #(
  parameter int unsigned CAPACITY = bdq_pkg::BDQ_CAPACITY
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  bdq_pkg::op_t       q_item_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] element_o,
  output logic               last_o
);
  import bdq_pkg::*;

  localparam int unsigned PW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C    = CW'(CAPACITY);
  localparam logic [PW-1:0] LAST_POS = PW'(CAPACITY - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  // Position of the element at a given offset from the front, modulo the capacity.
  function automatic logic [PW-1:0] ring_pos(input logic [PW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(CAPACITY)) begin
      sum = sum - (CW+1)'(CAPACITY);
    end
    return sum[PW-1:0];
  endfunction

  logic signed [31:0] mem_q [CAPACITY];
  logic signed [31:0] rd_data_q;

  logic [1:0]    state_q, state_d;
  logic [PW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  logic [PW-1:0] idx_q, idx_d;

  logic               out_valid_q;
  logic [1:0]         status_q;
  logic signed [31:0] element_q;
  logic               last_q;

  logic               out_free;
  logic               out_load;
  logic [1:0]         status_d;
  logic signed [31:0] element_d;
  logic               last_d;

  logic               wr_en;
  logic [PW-1:0]      wr_addr;
  logic               rd_en;
  logic [PW-1:0]      rd_addr;
  logic [PW-1:0]      front_dec;
  logic [CW-1:0]      idx_next;

  assign out_free  = !out_valid_q || out_ready_i;
  assign front_dec = (front_q == '0) ? LAST_POS : front_q - 1'b1;
  assign idx_next  = CW'(idx_q) + 1'b1;

  always_comb begin
    state_d   = state_q;
    front_d   = front_q;
    count_d   = count_q;
    idx_d     = idx_q;
    q_pop_o   = 1'b0;
    out_load  = 1'b0;
    status_d  = ST_OK;
    element_d = '0;
    last_d    = 1'b1;
    wr_en     = 1'b0;
    wr_addr   = '0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          unique case (q_item_i.op)
            OP_INS_REAR, OP_INS_FRONT: begin
              out_load = 1'b1;
              if (count_q == CAP_C) begin
                status_d = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                element_d = q_item_i.value;
                count_d   = count_q + 1'b1;
                if (q_item_i.op == OP_INS_REAR) begin
                  wr_addr = ring_pos(front_q, count_q);
                end else begin
                  wr_addr = front_dec;
                  front_d = front_dec;
                end
              end
            end
            OP_DEL_FRONT, OP_DEL_REAR: begin
              if (count_q == '0) begin
                out_load = 1'b1;
                status_d = ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                count_d = count_q - 1'b1;
                state_d = S_READ;
                if (q_item_i.op == OP_DEL_FRONT) begin
                  rd_addr = front_q;
                  front_d = (front_q == LAST_POS) ? '0 : front_q + 1'b1;
                end else begin
                  rd_addr = ring_pos(front_q, count_q - 1'b1);
                end
              end
            end
            OP_DUMP: begin
              if (count_q == '0) begin
                out_load = 1'b1;
                status_d = ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                rd_addr = front_q;
                idx_d   = '0;
                state_d = S_DUMP;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          out_load  = 1'b1;
          element_d = rd_data_q;
          state_d   = S_IDLE;
        end
      end
      S_DUMP: begin
        // The next entry is fetched while the current one moves to the output.
        if (out_free) begin
          out_load  = 1'b1;
          element_d = rd_data_q;
          last_d    = (idx_next == count_q);
          if (idx_next == count_q) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            rd_en   = 1'b1;
            rd_addr = ring_pos(front_q, idx_next);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q  <= status_d;
      element_q <= element_d;
      last_q    <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= q_item_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign element_o   = element_q;
  assign last_o      = last_q;

  `BDQ_ASSERT(a_count_range, clk_i, rst_ni, count_q <= CAP_C, "element count above capacity")
  `BDQ_ASSERT(a_err_zero, clk_i, rst_ni, (out_valid_q && status_q != ST_OK) |-> (element_q == '0), "error result with nonzero element")
  `BDQ_ASSERT_NEVER(a_dump_empty, clk_i, rst_ni, (state_q == S_DUMP) && (count_q == '0), "dump running on an empty store")

endmodule

@@ dv/bounded_double_ended_queue_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_top_tb
// Drives insert, delete and dump items into the bounded deque and predicts
// every result with a ring model of its own. Results are checked in order,
// field by field, while the sender idles in bursts and the receiver stalls.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_top_tb;
  import bdq_pkg::*;

  localparam int unsigned CAP          = BDQ_CAPACITY;
  localparam int unsigned POS_W        = $clog2(CAP);
  localparam int unsigned CNT_W        = $clog2(CAP + 1);
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned RANDOM_ITEMS = 145;
  localparam int unsigned END_TAIL     = 16;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned MAX_PRINTED  = 30;

  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

  typedef enum int unsigned {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_e;
  typedef enum int unsigned {RX_OPEN, RX_COIN, RX_PERIODIC, RX_BURSTY} rx_pattern_e;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic               last;
  } deque_result_t;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [2:0]         cmd_i       = CMD_INS_REAR;
  logic signed [31:0] value_i     = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         status_o;
  logic signed [31:0] element_o;
  logic               last_o;

  // Shadow of the deque and the results it still owes.
  logic signed [31:0] ring_shadow [CAP];
  logic [POS_W-1:0]   front_shadow = '0;
  logic [CNT_W-1:0]   count_shadow = '0;
  deque_result_t      pending_results [$];

  int unsigned burst_left = 1;
  int unsigned items_sent, results_checked, error_count;
  int unsigned dump_count, full_count, empty_count, unused_count;
  int unsigned idle_cycles, rx_cycles, rx_stall_left;

  bounded_double_ended_queue_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .element_o   (element_o),
    .last_o      (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [POS_W-1:0] ring_slot(int unsigned offset);
    return POS_W'((front_shadow + offset) % CAP);
  endfunction

  function automatic void owe_result(logic [1:0] status, logic signed [31:0] element,
                                     logic last);
    pending_results.push_back('{status: status, element: element, last: last});
  endfunction

  task automatic predict_deque(input logic [2:0] cmd, input logic signed [31:0] value);
    int unsigned i;
    case (cmd)
      CMD_INS_REAR, CMD_INS_FRONT: begin
        if (count_shadow >= CAP) begin
          owe_result(ST_FULL, '0, 1'b1);
          full_count++;
        end else begin
          if (cmd == CMD_INS_REAR) begin
            ring_shadow[ring_slot(count_shadow)] = value;
          end else begin
            front_shadow = POS_W'((front_shadow + CAP - 1) % CAP);
            ring_shadow[front_shadow] = value;
          end
          count_shadow++;
          owe_result(ST_OK, value, 1'b1);
        end
      end
      CMD_DEL_FRONT, CMD_DEL_REAR: begin
        if (count_shadow == 0) begin
          owe_result(ST_EMPTY, '0, 1'b1);
          empty_count++;
        end else begin
          if (cmd == CMD_DEL_FRONT) begin
            owe_result(ST_OK, ring_shadow[front_shadow], 1'b1);
            front_shadow = POS_W'((front_shadow + 1) % CAP);
          end else begin
            owe_result(ST_OK, ring_shadow[ring_slot(count_shadow - 1)], 1'b1);
          end
          count_shadow--;
        end
      end
      CMD_DUMP: begin
        dump_count++;
        if (count_shadow == 0) begin
          owe_result(ST_EMPTY, '0, 1'b1);
          empty_count++;
        end else begin
          for (i = 0; i < count_shadow; i++) begin
            owe_result(ST_OK, ring_shadow[ring_slot(i)], (i + 1 == count_shadow));
          end
        end
      end
      default: begin
        // Codes past the dump are dropped by the block without a result.
        unused_count++;
      end
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_result(input logic [1:0] status, input logic signed [31:0] element,
                              input logic last);
    deque_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result status=%0d element=%0d last=%0d",
                                status, element, last));
      return;
    end
    want = pending_results.pop_front();
    results_checked++;
    if (status !== want.status)
      report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
    if (element !== want.element)
      report_mismatch($sformatf("element %0d, expected %0d", element, want.element));
    if (last !== want.last)
      report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
  endtask

  // Called at a rising edge; returns when the item is taken or a burst gap ends.
  task automatic send_item(input logic [2:0] cmd, input logic signed [31:0] value);
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    value_i    <= value;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    predict_deque(cmd, value);
    burst_left--;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
    end
  endtask

  // Holds the sender off until every owed result has come back.
  task automatic wait_results_drained();
    if (in_valid_i) in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_command(mix_e mix);
    int unsigned roll;
    int unsigned insert_pct;
    roll = $urandom_range(0, 99);
    if (roll < 3) return 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    if (roll < 13) return CMD_DUMP;
    case (mix)
      MIX_FILL:  insert_pct = 70;
      MIX_DRAIN: insert_pct = 30;
      default:   insert_pct = 50;
    endcase
    if ($urandom_range(0, 99) < insert_pct)
      return $urandom_range(0, 1) ? CMD_INS_FRONT : CMD_INS_REAR;
    return $urandom_range(0, 1) ? CMD_DEL_FRONT : CMD_DEL_REAR;
  endfunction

  task automatic test_empty_store();
    send_item(CMD_DEL_FRONT, pick_value());
    send_item(CMD_DEL_REAR, pick_value());
    send_item(CMD_DUMP, pick_value());
  endtask

  // Alternating ends makes the front position wrap below zero.
  task automatic test_fill_to_full();
    logic signed [31:0] edge_values [4];
    edge_values = '{VAL_MAX, VAL_MIN, '0, -32'sd1};
    for (int i = 0; i < CAP; i++) begin
      send_item((i % 2) ? CMD_INS_FRONT : CMD_INS_REAR, (i < 4) ? edge_values[i] : $urandom);
    end
    send_item(CMD_INS_REAR, 32'sh1234_5678);
    send_item(CMD_INS_FRONT, VAL_MAX);
    send_item(CMD_DUMP, '0);
  endtask

  task automatic test_delete_ends();
    send_item(CMD_DEL_FRONT, VAL_MIN);
    send_item(CMD_DEL_REAR, VAL_MAX);
  endtask

  task automatic test_unused_commands();
    for (logic [3:0] c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++) send_item(c[2:0], $urandom);
    send_item(CMD_DUMP, '0);
  endtask

  task automatic test_drain_pause();
    send_item(CMD_INS_REAR, pick_value());
    send_item(CMD_DUMP, '0);
    wait_results_drained();
    send_item(CMD_DEL_FRONT, '0);
    send_item(CMD_DUMP, '0);
  endtask

  task automatic test_random_mix();
    int unsigned counted;
    mix_e mix;
    logic [2:0] cmd;
    counted = 0;
    mix = MIX_FILL;
    while (counted < RANDOM_ITEMS) begin
      if (counted % 30 == 0 && counted != 0) mix = mix_e'($urandom_range(0, 2));
      cmd = pick_command(mix);
      send_item(cmd, pick_value());
      if (cmd <= CMD_DUMP) counted++;
      if ($urandom_range(0, 49) == 0) wait_results_drained();
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_store();
    test_fill_to_full();
    test_delete_ends();
    test_unused_commands();
    test_drain_pause();
    test_random_mix();
    wait_results_drained();
    repeat (END_TAIL) @(posedge clk_i);
    $display("Sent %0d items: %0d dumps, %0d full rejects, %0d empty reports, %0d unused codes.",
             items_sent, dump_count, full_count, empty_count, unused_count);
    $display("Checked %0d results, %0d mismatches.", results_checked, error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Receiver: a stall pattern that moves through open, coin-flip, periodic
  // and bursty phases.
  always @(posedge clk_i) begin : rx_side
    logic ready_nxt;
    if (rst_ni && out_valid_o && out_ready_i) check_result(status_o, element_o, last_o);
    rx_cycles <= rx_cycles + 1;
    ready_nxt = 1'b1;
    if (rx_stall_left != 0) begin
      rx_stall_left <= rx_stall_left - 1;
      ready_nxt = 1'b0;
    end else begin
      case (rx_pattern_e'((rx_cycles / 150) % 4))
        RX_OPEN:     ready_nxt = 1'b1;
        RX_COIN:     ready_nxt = 1'($urandom_range(0, 1));
        RX_PERIODIC: ready_nxt = (rx_cycles % 3) == 0;
        default: begin
          if ($urandom_range(0, 4) == 0) begin
            rx_stall_left <= $urandom_range(2, 15);
            ready_nxt = 1'b0;
          end
        end
      endcase
    end
    out_ready_i <= ready_nxt;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no item moved for %0d cycles, %0d results still owed.",
               idle_cycles, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
